[rtl/tsf_pkg.sv]
// Shared types, codes and helpers for the temperature display formatter.
package tsf_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int HALF_COUNT  = DIGIT_COUNT / 2;
    localparam int SCALED_W    = 14;               // scaled values stay below 10000

    // display mode selector
    localparam logic [1:0] MODE_C    = 2'd0;
    localparam logic [1:0] MODE_OFF  = 2'd1;
    localparam logic [1:0] MODE_F    = 2'd2;
    localparam logic [1:0] MODE_BOTH = 2'd3;

    // digit codes
    localparam logic [4:0] CODE_BLANK  = 5'd16;
    localparam logic [4:0] CODE_UNIT_C = 5'd12;
    localparam logic [4:0] CODE_UNIT_F = 5'd15;

    // decimal point masks
    localparam logic [7:0] PT_HI_X100 = 8'h40;
    localparam logic [7:0] PT_HI_X10  = 8'h20;
    localparam logic [7:0] PT_LO_X100 = 8'h04;
    localparam logic [7:0] PT_LO_X10  = 8'h02;

    typedef logic [HALF_COUNT-1:0][3:0] bcd_t;   // four decimal digits, [0] least significant
    typedef logic [SCALED_W-1:0]        scaled_t;

    // Split 0..99 into tens and ones: tens = (x*205) >> 11 is exact below 180.
    function automatic logic [7:0] split99(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [7:0]  ones;
        prod = 15'(x) * 15'd205;
        tens = prod[14:11];
        ones = 8'(x) - 8'(tens) * 8'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

[rtl/temperature_to_seven_segment_format.sv]
// Top level of the temperature to seven-segment digit formatter.
//
// Takes one sensor word per cycle (bits 15..3 a 13-bit two's complement count of
// sixteenths of a degree) with a two-bit mode on s_tuser (0 Celsius, 1 off,
// 2 Fahrenheit, 3 both) and returns eight digit codes (0..9 decimal digit, 12 = C,
// 15 = F, 16 = blank) plus a decimal-point mask. Celsius is r/16, Fahrenheit is
// r*9/80+32; a value below 100 degrees shows as floor(value*100), otherwise as
// floor(value*10); negative values show as zero. Single modes place the unit
// letter just below the digits, with the most significant digit at position 7;
// both mode puts Celsius digits from position 0 and Fahrenheit from position 4,
// without letters. Throughput is one word per cycle while the result side is not stalled;
// the five register stages are scaling, reciprocal multiply by 1/100, remainder,
// tens/ones split, and digit placement into the output register. A stall on the
// result side holds every occupied stage and fills empty ones, so the input keeps
// accepting until the whole pipeline is full.
module temperature_to_seven_segment_format
    import tsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] raw_reading
    input  logic [1:0]  s_tuser,   // [1:0] buttons
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] digit0, [9:5] digit1, [14:10] digit2, [19:15] digit3,
    // [24:20] digit4, [29:25] digit5, [34:30] digit6, [39:35] digit7, [47:40] point_mask
    output logic [47:0] m_tdata
);

    localparam int STAGES = 5;

    // side band that rides along with each word
    typedef struct packed {
        logic [1:0] mode;
        logic       c_big;
        logic       f_big;
    } side_t;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;
    side_t             side_reg [STAGES-1];
    scaled_t           c_val_reg;
    scaled_t           f_val_reg;
    bcd_t              c_dig;
    bcd_t              f_dig;
    logic [47:0]       out_reg;

    // ---------------- flow control ----------------
    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: decode, clamp, scale ----------------
    logic signed [12:0] r_in;
    logic [11:0]        c_v;
    logic signed [16:0] f_num;
    logic [15:0]        f_v;
    logic               c_big;
    logic               f_big;
    logic [16:0]        c_x25;
    logic [17:0]        f_x5;
    logic [14:0]        c_x5;
    scaled_t            c_scaled;
    scaled_t            f_scaled;

    always_comb begin
        r_in  = signed'(s_tdata[15:3]);
        c_v   = r_in[12] ? 12'd0 : r_in[11:0];
        f_num = 17'(r_in) * 17'sd9 + 17'sd2560;
        f_v   = f_num[16] ? 16'd0 : f_num[15:0];
        c_big = c_v >= 12'd1600;
        f_big = f_v >= 16'd8000;
        c_x25 = (17'(c_v) << 4) + (17'(c_v) << 3) + 17'(c_v);
        c_x5  = (15'(c_v) << 2) + 15'(c_v);
        f_x5  = (18'(f_v) << 2) + 18'(f_v);
        // x100 / 16 = x25 / 4, x10 / 16 = x5 / 8; x100 / 80 = x5 / 4, x10 / 80 = x / 8
        c_scaled = c_big ? SCALED_W'(c_x5 >> 3) : SCALED_W'(c_x25 >> 2);
        f_scaled = f_big ? SCALED_W'(f_v >> 3)  : SCALED_W'(f_x5 >> 2);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            c_val_reg   <= c_scaled;
            f_val_reg   <= f_scaled;
            side_reg[0] <= '{mode: s_tuser, c_big: c_big, f_big: f_big};
        end
        for (int k = 1; k < STAGES - 1; k++) begin
            if (adv[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- stages 1..3: decimal conversion ----------------
    tsf_bcd u_bcd_c (
        .aclk     (aclk),
        .stage_en (adv[3:1]),
        .value_i  (c_val_reg),
        .digits_o (c_dig)
    );

    tsf_bcd u_bcd_f (
        .aclk     (aclk),
        .stage_en (adv[3:1]),
        .value_i  (f_val_reg),
        .digits_o (f_dig)
    );

    // ---------------- stage 4: digit placement ----------------
    side_t       sd;
    logic [2:0]  c_cnt;
    logic [2:0]  f_cnt;
    logic [2:0]  one_cnt;
    bcd_t        one_dig;
    logic [4:0]  one_unit;
    logic        one_big;
    logic [2:0]  pos;
    logic [2:0]  idx;
    logic [4:0]  d [DIGIT_COUNT];
    logic [7:0]  mask;
    logic [47:0] out_next;

    function automatic logic [2:0] count_digits(input bcd_t v);
        logic [2:0] n;
        if (v[3] != 4'd0)      n = 3'd4;
        else if (v[2] != 4'd0) n = 3'd3;
        else if (v[1] != 4'd0) n = 3'd2;
        else                   n = 3'd1;
        return n;
    endfunction

    always_comb begin
        sd       = side_reg[STAGES-2];
        c_cnt    = count_digits(c_dig);
        f_cnt    = count_digits(f_dig);
        one_cnt  = (sd.mode == MODE_F) ? f_cnt : c_cnt;
        one_dig  = (sd.mode == MODE_F) ? f_dig : c_dig;
        one_unit = (sd.mode == MODE_F) ? CODE_UNIT_F : CODE_UNIT_C;
        one_big  = (sd.mode == MODE_F) ? sd.f_big : sd.c_big;
        pos      = 3'(DIGIT_COUNT - 1) - one_cnt;
        idx      = '0;
        mask     = '0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            d[i] = CODE_BLANK;
        end
        case (sd.mode)
            MODE_C, MODE_F: begin
                // letter at pos, digits above it, blanks below
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    idx = 3'(i) - pos - 3'd1;
                    if (3'(i) == pos) begin
                        d[i] = one_unit;
                    end else if (3'(i) > pos) begin
                        d[i] = {1'b0, one_dig[idx[1:0]]};
                    end
                end
                mask = one_big ? PT_HI_X10 : PT_HI_X100;
            end
            MODE_BOTH: begin
                for (int i = 0; i < HALF_COUNT; i++) begin
                    if (3'(i) < c_cnt) begin
                        d[i] = {1'b0, c_dig[i]};
                    end
                    if (3'(i) < f_cnt) begin
                        d[HALF_COUNT + i] = {1'b0, f_dig[i]};
                    end
                end
                mask = (sd.f_big ? PT_HI_X10 : PT_HI_X100) | (sd.c_big ? PT_LO_X10 : PT_LO_X100);
            end
            default: begin
                // display off: leave all blank, no points
                mask = '0;
            end
        endcase
        out_next = {mask, d[7], d[6], d[5], d[4], d[3], d[2], d[1], d[0]};
    end

    always_ff @(posedge aclk) begin
        if (adv[STAGES-1]) begin
            out_reg <= out_next;
        end
    end

endmodule

[rtl/tsf_bcd.sv]
// Three-stage binary to four-digit decimal converter for values below 10000.
module tsf_bcd
    import tsf_pkg::*;
(
    input  logic       aclk,
    input  logic [2:0] stage_en,
    input  scaled_t    value_i,
    output bcd_t       digits_o
);

    logic [SCALED_W-1:0] val_a_reg;
    logic [6:0]          quo_a_reg;
    logic [6:0]          quo_b_reg;
    logic [6:0]          rem_b_reg;
    bcd_t                dig_reg;

    logic [26:0]         prod;
    logic [SCALED_W-1:0] rem_full;
    logic [7:0]          hi_split;
    logic [7:0]          lo_split;

    // quotient by 100 through a reciprocal: 5243 / 2^19 errs high by under 0.003 here
    assign prod     = 27'(value_i) * 27'd5243;
    assign rem_full = val_a_reg - SCALED_W'(quo_a_reg) * SCALED_W'(100);
    assign hi_split = split99(quo_b_reg);
    assign lo_split = split99(rem_b_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            val_a_reg <= value_i;
            quo_a_reg <= prod[25:19];
        end
        if (stage_en[1]) begin
            quo_b_reg <= quo_a_reg;
            rem_b_reg <= rem_full[6:0];
        end
        if (stage_en[2]) begin
            dig_reg <= {hi_split[7:4], hi_split[3:0], lo_split[7:4], lo_split[3:0]};
        end
    end

    assign digits_o = dig_reg;

endmodule

[rtl/tsf_checker.sv]
// Port-level checker for the temperature formatter, bound to the top level.
module tsf_checker
    import tsf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    localparam logic [39:0] ALL_BLANK = {DIGIT_COUNT{CODE_BLANK}};

    // a stalled result holds its word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input backpressure only when a result is waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // no decimal points means display off: every position blank
    a_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[47:40] == 8'h00) |-> m_tdata[39:0] == ALL_BLANK)
        else $error("dark point mask with lit digits");

endmodule

bind temperature_to_seven_segment_format tsf_checker u_tsf_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the temperature to seven-segment digit formatter, with its display predictor.
module tb_top;
    import tsf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // slowest legal run stays far below this
    localparam int HOLD_CYCLES  = 80;      // long receiver hold-off, fills the pipeline
    localparam int DRAIN_CYCLES = 20;      // pipeline is five stages deep
    localparam int RANDOM_RUN   = 700;
    localparam int BURST_RUN    = 40;
    localparam int TAIL_RUN     = 360;

    // readings r (sixteenths of a degree) sitting on or next to a boundary:
    // Celsius 100 degrees, Fahrenheit 100 degrees, Fahrenheit zero, Celsius zero
    localparam int EDGE_R[8]    = '{1600, 1599, 605, 604, -285, -284, 0, -1};
    localparam int EXTREME_R[4] = '{4095, -4096, -1, 0};

    // one display result, laid out exactly as m_tdata: digit0 in the lowest bits
    typedef struct packed {
        logic [7:0]                   points;
        logic [DIGIT_COUNT-1:0][4:0]  digit;
    } display_t;

    // Predicts each display from an accepted reading and matches results in order.
    class display_ledger;
        display_t pending_displays[$];
        int       failures;

        // Clamp at zero, pick the x10 scale at 100 degrees or more, floor the division.
        static function int scale_temp(input int num, input int den, output bit coarse);
            int v;
            v = (num < 0) ? 0 : num;
            coarse = (v >= 100 * den);
            return coarse ? (v * 10) / den : (v * 100) / den;
        endfunction

        static function int digit_len(input int v);
            int n;
            n = 1;
            while (v >= 10) begin
                v = v / 10;
                n++;
            end
            return n;
        endfunction

        static function display_t format_reading(input logic [15:0] raw,
                                                 input logic [1:0] mode);
            display_t d;
            int       r;
            int       c_val;
            int       f_val;
            int       val;
            int       at;
            bit       c_coarse;
            bit       f_coarse;
            bit       coarse;
            r = $signed(raw[15:3]);
            for (int i = 0; i < DIGIT_COUNT; i++) d.digit[i] = CODE_BLANK;
            d.points = '0;
            c_val = scale_temp(r, 16, c_coarse);
            f_val = scale_temp(r * 9 + 2560, 80, f_coarse);
            case (mode)
                MODE_C, MODE_F: begin
                    val    = (mode == MODE_C) ? c_val : f_val;
                    coarse = (mode == MODE_C) ? c_coarse : f_coarse;
                    at = DIGIT_COUNT - digit_len(val) - 1;
                    d.digit[at] = (mode == MODE_C) ? CODE_UNIT_C : CODE_UNIT_F;
                    for (int i = at + 1; i < DIGIT_COUNT; i++) begin
                        d.digit[i] = 5'(val % 10);
                        val = val / 10;
                    end
                    d.points = coarse ? PT_HI_X10 : PT_HI_X100;
                end
                MODE_BOTH: begin
                    at = digit_len(c_val);
                    for (int i = 0; i < at && i < HALF_COUNT; i++) begin
                        d.digit[i] = 5'(c_val % 10);
                        c_val = c_val / 10;
                    end
                    at = digit_len(f_val);
                    for (int i = 0; i < at && i < HALF_COUNT; i++) begin
                        d.digit[HALF_COUNT + i] = 5'(f_val % 10);
                        f_val = f_val / 10;
                    end
                    d.points = (f_coarse ? PT_HI_X10 : PT_HI_X100)
                             | (c_coarse ? PT_LO_X10 : PT_LO_X100);
                end
                default: begin
                    // display off: everything blank, no points
                end
            endcase
            return d;
        endfunction

        function void note_reading(input logic [15:0] raw, input logic [1:0] mode);
            pending_displays.push_back(format_reading(raw, mode));
        endfunction

        function void check_display(input logic [47:0] word);
            display_t want;
            display_t got;
            if (pending_displays.size() == 0) begin
                $error("display word 0x%012h arrived with no reading outstanding", word);
                failures++;
                return;
            end
            want = pending_displays.pop_front();
            got  = display_t'(word);
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (got.digit[i] !== want.digit[i]) begin
                    $error("digit%0d expected %0d actual %0d", i, want.digit[i], got.digit[i]);
                    failures++;
                end
            end
            if (got.points !== want.points) begin
                $error("point_mask expected 0x%02h actual 0x%02h", want.points, got.points);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_displays.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] raw_reading
    logic [1:0]  s_tuser;    // [1:0] buttons
    logic        m_tvalid;
    logic        m_tready;
    // [4:0] digit0 ... [39:35] digit7, [47:40] point_mask
    logic [47:0] m_tdata;

    display_ledger ledger = new();
    bit            receiver_hold;   // raised by the sender, cleared by the receiver
    bit            quiet_tail;      // no idling on either side from here on
    int            cycle_count;

    temperature_to_seven_segment_format i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sample both handshakes at the rising edge; inputs only move at the falling edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) ledger.note_reading(s_tdata, s_tuser);
            if (m_tvalid && m_tready) ledger.check_display(m_tdata);
        end
    end

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[temperature_to_seven_segment_format] ERROR");
            $finish;
        end
    end

    // Place r in bits 15..3; the three ignored low bits get random values.
    function automatic logic [15:0] reading_word(input int r);
        return {r[12:0], 3'($urandom_range(0, 7))};
    endfunction

    // Half raw noise; the rest weighted to in-range, boundary and extreme readings.
    function automatic logic [15:0] random_reading();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6, 7:       return reading_word(int'($urandom_range(0, 2000)));
            8:             return reading_word(EDGE_R[$urandom_range(0, 7)]
                                               + int'($urandom_range(0, 4)) - 2);
            default:       return reading_word(EXTREME_R[$urandom_range(0, 3)]);
        endcase
    endfunction

    // Offer one word and hold it until accepted; return at the next falling edge.
    task automatic send_reading(input logic [15:0] raw, input logic [1:0] mode);
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid for a short random burst, now and then.
    task automatic sender_gap();
        if ($urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
    endtask

    task automatic send_random_run(input int count);
        bit calm;
        calm = 1'b0;
        for (int i = 0; i < count; i++) begin
            // alternate stretches of steady offering with gappy ones
            if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            send_reading(random_reading(), 2'($urandom_range(0, 3)));
            if (!calm) sender_gap();
        end
    endtask

    // Receiver side: random stall bursts, ready stretches, and one long hold-off
    // on request, timed here in its own cycles.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (receiver_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
                receiver_hold = 1'b0;
            end else if (quiet_tail) begin
                m_tready <= 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
                    end
                    2: begin
                        m_tready <= 1'b1;
                        repeat (19) @(negedge aclk);
                    end
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Sender side and run control.
    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_C;
        receiver_hold = 1'b0;
        quiet_tail    = 1'b0;
        cycle_count   = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: zero in every mode, the extremes, negative clamping,
        // and both sides of each scale boundary.
        send_reading(reading_word(0), MODE_C);
        send_reading(reading_word(0), MODE_F);
        send_reading(reading_word(0), MODE_BOTH);
        send_reading(reading_word(0), MODE_OFF);
        send_reading(16'hFFFF, MODE_C);
        send_reading(16'hFFFF, MODE_F);
        send_reading(16'hFFFF, MODE_BOTH);
        send_reading(16'hFFFF, MODE_OFF);
        send_reading(16'h7FFF, MODE_C);
        send_reading(16'h7FFF, MODE_F);
        send_reading(16'h7FFF, MODE_BOTH);
        send_reading(16'h8000, MODE_C);
        send_reading(16'h8000, MODE_F);
        send_reading(16'h8000, MODE_BOTH);
        send_reading(reading_word(1600), MODE_C);
        send_reading(reading_word(1599), MODE_C);
        send_reading(reading_word(605), MODE_F);
        send_reading(reading_word(604), MODE_F);
        send_reading(reading_word(-285), MODE_F);
        send_reading(reading_word(-284), MODE_F);
        send_reading(reading_word(1600), MODE_BOTH);
        send_reading(reading_word(605), MODE_BOTH);
        send_reading(reading_word(-285), MODE_BOTH);

        send_random_run(RANDOM_RUN);

        // Hold the receiver off and keep offering back to back until the input stalls.
        receiver_hold = 1'b1;
        for (int i = 0; i < BURST_RUN; i++)
            send_reading(random_reading(), 2'($urandom_range(0, 3)));

        // Pause until every display outstanding has come back.
        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(negedge aclk);

        send_random_run(RANDOM_RUN);

        // Final stretch at full rate on both sides.
        quiet_tail = 1'b1;
        for (int i = 0; i < TAIL_RUN; i++)
            send_reading(random_reading(), 2'($urandom_range(0, 3)));

        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (ledger.failures == 0) begin
            $display("[temperature_to_seven_segment_format] OK");
        end else begin
            $display("[temperature_to_seven_segment_format] ERROR");
        end
        $finish;
    end

endmodule
